### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deque checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define DQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deque assertion failed");

// implication shorthand on top of DQ_ASSERT
`define DQ_IMPLIES(lbl, clk, rst_n, cond, expr) \
  `DQ_ASSERT(lbl, clk, rst_n, (cond) |-> (expr))

`endif

### design/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the double-ended queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned InW    = 40;
  localparam int unsigned OutW   = 40;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_AT    = 3'd4
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } dq_status_t;

  // result bookkeeping while the memory read is in flight
  typedef struct packed {
    logic              valid;
    logic              use_rd;
    dq_status_t        status;
    logic [CountW-1:0] count;
  } dq_pend_t;

endpackage

`default_nettype wire

### design/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of data words kept in a single-port ring buffer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one command beat carries an op (push front, push
//   back, pop front, pop back, read at position), a data word and a
//   position. Output channel out_*: one result beat per command with the
//   word popped or read, a status code and the entry count after the op.
//   Path: a taken command loads the read stage (result bookkeeping and the
//   store's read register), which then loads the result register.
//   Throughput: one command per cycle; the entry store is touched at most
//   once per command (one write or one read) on its single port, so commands
//   flow back to back while results are drained.
//   Stall: when out_tready is low the result sits in the output register;
//   one more result may wait in the read stage, after which in_tready drops.
//   Reset: rst_n low empties the queue (front pointer and count cleared)
//   and drops out_tvalid. Store contents are not cleared; empty slots are
//   never read.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  // [2:0] op, [34:3] data_in, [38:35] position, [39] zero
  input  wire logic [InW-1:0]  in_tdata,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  // [31:0] data_out, [33:32] status, [38:34] entry_count, [39] zero
  output logic      [OutW-1:0] out_tdata
);

  localparam int unsigned SW = (DATA_WIDTH < WordW) ? DATA_WIDTH : WordW;
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic             accept;
  logic             adv;
  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_addr;
  logic [SW-1:0]    mem_wdata;
  logic [SW-1:0]    mem_rdata_r;
  dq_pend_t         pend_r;

  logic              out_valid_r, out_valid_nxt;
  logic [WordW-1:0]  out_data_r, out_data_nxt;
  dq_status_t        out_status_r, out_status_nxt;
  logic [CountW-1:0] out_count_r, out_count_nxt;

  assign adv       = pend_r.valid && (!out_valid_r || out_tready);
  assign in_tready = !pend_r.valid || adv;
  assign accept    = in_tvalid && in_tready;

  dq_ctrl #(
    .DEPTH (DEPTH),
    .SW    (SW),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .adv       (adv),
    .op        (in_tdata[2:0]),
    .data_in   (in_tdata[34:3]),
    .position  (in_tdata[38:35]),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .pend_r    (pend_r)
  );

  dq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (SW),
    .IW    (IW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata_r)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = pend_r.use_rd ? WordW'(mem_rdata_r) : '0;
      out_status_nxt = pend_r.status;
      out_count_nxt  = pend_r.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_status_r, out_data_r};

endmodule

`default_nettype wire

### design/dq_ram.sv
// ---------------------------------------------------------------------------
// dq_ram
// Single-port entry store, synchronous write, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned IW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [IW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### design/dq_ctrl.sv
// ---------------------------------------------------------------------------
// dq_ctrl
// Ring pointers, operation decode and memory access generation.
// ---------------------------------------------------------------------------
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned SW    = 32,
  parameter int unsigned IW    = 4,
  parameter int unsigned CW    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             adv,
  input  wire logic [OpW-1:0]   op,
  input  wire logic [WordW-1:0] data_in,
  input  wire logic [PosW-1:0]  position,
  output logic                  mem_we,
  output logic                  mem_re,
  output logic      [IW-1:0]    mem_addr,
  output logic      [SW-1:0]    mem_wdata,
  output dq_pend_t              pend_r
);

  localparam int unsigned SumW = IW + 1;
  localparam int unsigned CmpW = CW + PosW;

  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  dq_pend_t      pend_nxt;
  logic [IW-1:0] offset;
  logic [SumW-1:0] sum;
  logic [IW-1:0] slot;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic          full, empty, out_of_range;
  logic          we_c, re_c;
  dq_status_t    status_c;
  logic [IW-1:0] addr_c;

  assign full         = (occ_r == CW'(DEPTH));
  assign empty        = (occ_r == '0);
  assign out_of_range = (CmpW'(position) >= CmpW'(occ_r));
  assign front_dec    = (front_r == '0) ? IW'(DEPTH - 1) : front_r - IW'(1);
  assign front_inc    = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + IW'(1);

  always_comb begin
    offset = '0;
    case (dq_op_t'(op))
      OP_PUSH_BACK: offset = IW'(occ_r);
      OP_POP_BACK:  offset = IW'(occ_r - CW'(1));
      OP_READ_AT:   offset = IW'(position);
      default:      offset = '0;
    endcase
  end

  assign sum  = {1'b0, front_r} + {1'b0, offset};
  assign slot = (sum >= SumW'(DEPTH)) ? IW'(sum - SumW'(DEPTH)) : IW'(sum);

  always_comb begin
    we_c      = 1'b0;
    re_c      = 1'b0;
    addr_c    = slot;
    status_c  = ST_OK;
    front_nxt = front_r;
    occ_nxt   = occ_r;
    case (dq_op_t'(op))
      OP_PUSH_FRONT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          we_c      = 1'b1;
          addr_c    = front_dec;
          front_nxt = front_dec;
          occ_nxt   = occ_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          we_c    = 1'b1;
          occ_nxt = occ_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          re_c      = 1'b1;
          addr_c    = front_r;
          front_nxt = front_inc;
          occ_nxt   = occ_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          re_c    = 1'b1;
          occ_nxt = occ_r - CW'(1);
        end
      end
      OP_READ_AT: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (out_of_range) begin
          status_c = ST_RANGE;
        end else begin
          re_c = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we    = accept && we_c;
  assign mem_re    = accept && re_c;
  assign mem_addr  = addr_c;
  assign mem_wdata = SW'(data_in);

  always_comb begin
    pend_nxt = pend_r;
    if (adv) begin
      pend_nxt.valid = 1'b0;
    end
    if (accept) begin
      pend_nxt.valid  = 1'b1;
      pend_nxt.use_rd = re_c;
      pend_nxt.status = status_c;
      pend_nxt.count  = CountW'(occ_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
      pend_r  <= '0;
    end else begin
      if (accept) begin
        front_r <= front_nxt;
        occ_r   <= occ_nxt;
      end
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

### design/dq_checker.sv
// ---------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dq_checker
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_tvalid,
  input wire logic            in_tready,
  input wire logic            out_tvalid,
  input wire logic            out_tready,
  input wire logic [OutW-1:0] out_tdata
);

  logic              in_beat;
  logic              out_wait;
  logic [WordW-1:0]  res_data;
  dq_status_t        res_status;
  logic [CountW-1:0] res_count;

  assign in_beat    = in_tvalid && in_tready;
  assign out_wait   = out_tvalid && !out_tready;
  assign res_data   = out_tdata[31:0];
  assign res_status = dq_status_t'(out_tdata[33:32]);
  assign res_count  = out_tdata[38:34];

  `DQ_ASSERT(a_out_hold, clk, rst_n, out_wait |=> (out_tvalid && $stable(out_tdata)))
  `DQ_ASSERT(a_in_result, clk, rst_n, in_beat |=> ##1 out_tvalid)
  `DQ_IMPLIES(a_err_zero, clk, rst_n, out_tvalid && (res_status != ST_OK), res_data == '0)
  `DQ_IMPLIES(a_empty_cnt, clk, rst_n, out_tvalid && (res_status == ST_EMPTY), res_count == '0)
  `DQ_IMPLIES(a_full_cnt, clk, rst_n, out_tvalid && (res_status == ST_FULL), res_count == CountW'(DEPTH))

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/double_ended_queue_tb.sv
// ---------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque. Command beats go in through
// a driver fed from a pending list; a local deque predictor tracks the
// front slot, the occupancy and the stored words, and each result beat is
// compared field by field with the oldest predicted result. Directed
// corner cases come first, then push-heavy, pop-heavy, mixed and read-heavy
// stretches with random content and random gaps on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int Depth       = 16;
  localparam int RandomItems = 2000;
  localparam int CalmItems   = 200;
  localparam int StallLimit  = 2000;
  localparam int LongHold    = 120;
  localparam int LongHoldAt  = 400;
  localparam int TailCycles  = 8;

  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [WordW-1:0] word;
    logic [PosW-1:0]  pos;
    bit               drain_first;
  } dq_cmd_t;

  typedef struct {
    logic [WordW-1:0]  word;
    dq_status_t        status;
    logic [CountW-1:0] count;
  } dq_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutW-1:0] out_tdata;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dq_cmd_t cmd_fifo[$];
  dq_res_t expected_results[$];

  logic [WordW-1:0]  dq_slots [Depth];
  logic [PosW-1:0]   dq_head = '0;
  logic [CountW-1:0] dq_fill = '0;

  bit in_taken = 1'b0;
  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  function automatic dq_res_t deque_apply(input dq_cmd_t c);
    dq_res_t r;
    logic [PosW-1:0] slot;
    r.word = '0;
    r.status = ST_OK;
    case (c.op)
      OP_PUSH_FRONT: begin
        if (dq_fill == Depth) begin
          r.status = ST_FULL;
        end else begin
          dq_head = dq_head - 1'b1;
          dq_slots[dq_head] = c.word;
          dq_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (dq_fill == Depth) begin
          r.status = ST_FULL;
        end else begin
          slot = dq_head + dq_fill[PosW-1:0];
          dq_slots[slot] = c.word;
          dq_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (dq_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = dq_slots[dq_head];
          dq_head = dq_head + 1'b1;
          dq_fill--;
        end
      end
      OP_POP_BACK: begin
        if (dq_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = dq_head + PosW'(dq_fill - 1'b1);
          r.word = dq_slots[slot];
          dq_fill--;
        end
      end
      OP_READ_AT: begin
        if (dq_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (CountW'(c.pos) >= dq_fill) begin
          r.status = ST_RANGE;
        end else begin
          slot = dq_head + c.pos;
          r.word = dq_slots[slot];
        end
      end
      default: ;
    endcase
    r.count = dq_fill;
    return r;
  endfunction

  task automatic add_cmd(input logic [OpW-1:0] op, input logic [WordW-1:0] word,
                         input logic [PosW-1:0] pos, input bit drain_first);
    dq_cmd_t c;
    c.op = op;
    c.word = word;
    c.pos = pos;
    c.drain_first = drain_first;
    cmd_fifo.push_back(c);
  endtask

  initial begin
    int mode;
    int run_len;
    int roll;
    int made;
    logic [OpW-1:0] op;
    logic [WordW-1:0] word;

    // empty-queue cases and spare op codes
    add_cmd(OP_READ_AT, '0, '0, 1'b0);
    add_cmd(OP_POP_FRONT, '0, '0, 1'b0);
    add_cmd(OP_POP_BACK, '0, '0, 1'b0);
    for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
      add_cmd(k[OpW-1:0], '1, '1, 1'b0);
    // front insert wraps the head below slot zero
    add_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF, '0, 1'b0);
    add_cmd(OP_PUSH_BACK, 32'h0000_0000, '0, 1'b0);
    add_cmd(OP_PUSH_BACK, 32'h8000_0001, '0, 1'b0);
    for (int k = 0; k < 4; k++)
      add_cmd(OP_READ_AT, '0, k[PosW-1:0], 1'b0);
    add_cmd(OP_READ_AT, '0, '1, 1'b0);
    add_cmd(OP_SPARE_HI, 32'h1234_5678, '0, 1'b0);
    add_cmd(OP_POP_BACK, '0, '0, 1'b0);
    add_cmd(OP_POP_FRONT, '0, '0, 1'b0);
    add_cmd(OP_POP_FRONT, '0, '0, 1'b0);
    add_cmd(OP_POP_BACK, '0, '0, 1'b0);
    add_cmd(OP_READ_AT, '0, '0, 1'b0);

    made = 0;
    while (made < RandomItems) begin
      mode = $urandom_range(3, 0);
      run_len = $urandom_range(40, 8);
      for (int n = 0; n < run_len && made < RandomItems; n++) begin
        roll = $urandom_range(99, 0);
        if (roll < 2) begin
          op = OpW'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end else begin
          case (mode)
            0: op = (roll < 87) ? ($urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT) :
                    (roll < 94) ? ($urandom_range(1, 0) ? OP_POP_BACK : OP_POP_FRONT) :
                    OP_READ_AT;
            1: op = (roll < 87) ? ($urandom_range(1, 0) ? OP_POP_BACK : OP_POP_FRONT) :
                    (roll < 94) ? ($urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT) :
                    OP_READ_AT;
            2: op = OpW'($urandom_range(OP_READ_AT, OP_PUSH_FRONT));
            default: op = (roll < 60) ? OP_READ_AT :
                          (roll < 80) ? ($urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT) :
                          ($urandom_range(1, 0) ? OP_POP_BACK : OP_POP_FRONT);
          endcase
        end
        case ($urandom_range(15, 0))
          0: word = '0;
          1: word = '1;
          default: word = $urandom;
        endcase
        add_cmd(op, word, PosW'($urandom_range(15, 0)), made == 700 || made == 1400);
        made++;
      end
    end
  end

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (cmd_fifo.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // command driver
  always @(negedge clk) begin : cmd_drive
    logic offer;
    logic [InW-1:0] beat;
    dq_cmd_t nxt;
    int send_gap;
    int send_odds;
    int send_cyc;
    if (rst_n) begin
      send_cyc++;
      if (send_cyc % 128 == 0) send_odds = $urandom_range(3, 0);
      offer = in_tvalid && !in_taken;
      beat = in_tdata;
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_fifo.size() >= CalmItems && send_odds != 0 &&
                     $urandom_range(15, 0) < send_odds) begin
          send_gap = $urandom_range(10, 1) - 1;
        end else if (cmd_fifo.size() != 0 &&
                     !(cmd_fifo[0].drain_first && expected_results.size() != 0)) begin
          nxt = cmd_fifo.pop_front();
          beat = {1'b0, nxt.pos, nxt.word, nxt.op};
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
      in_tdata <= beat;
    end
  end

  // result receiver
  always @(negedge clk) begin : res_accept
    logic ready_next;
    int hold_left;
    int gap_left;
    int recv_odds;
    int recv_cyc;
    bit hold_done;
    if (rst_n) begin
      recv_cyc++;
      if (recv_cyc % 128 == 64) recv_odds = $urandom_range(3, 0);
      ready_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= LongHoldAt) begin
        hold_done = 1'b1;
        hold_left = LongHold - 1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_fifo.size() >= CalmItems && recv_odds != 0 &&
                   $urandom_range(15, 0) < recv_odds) begin
        gap_left = $urandom_range(10, 1) - 1;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  // predict on command beats, check result beats
  always @(posedge clk) begin : track
    dq_cmd_t c;
    dq_res_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        c.op = in_tdata[2:0];
        c.word = in_tdata[34:3];
        c.pos = in_tdata[38:35];
        c.drain_first = 1'b0;
        expected_results.push_back(deque_apply(c));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_tdata[31:0] !== e.word) begin
            $error("data_out: expected %h, got %h", e.word, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[33:32] !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_tdata[33:32]);
            fail_count++;
          end
          if (out_tdata[38:34] !== e.count) begin
            $error("entry_count: expected %0d, got %0d", e.count, out_tdata[38:34]);
            fail_count++;
          end
        end
      end
    end
    in_taken <= in_tvalid && in_tready;
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
